/* rtl/uvc_payload_frame_assembler_macros.svh */
// ----------------------------------------------------------------------------
// uvc_payload_frame_assembler_macros.svh
// Assertion macros for the payload frame assembler; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef UVC_PAYLOAD_FRAME_ASSEMBLER_MACROS_SVH
`define UVC_PAYLOAD_FRAME_ASSEMBLER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define UVC_PFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("uvc_pfa: assertion failed");
// Next-cycle implication, disabled while reset is low.
`define UVC_PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("uvc_pfa: assertion failed");
`else
`define UVC_PFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define UVC_PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/uvc_pfa_pkg.sv */
// ----------------------------------------------------------------------------
// uvc_pfa_pkg
// Types and constants shared by the payload frame assembler modules.
// ----------------------------------------------------------------------------
package uvc_pfa_pkg;

  localparam int MAX_PACKET_BYTES = 16384;
  localparam int MAX_FRAME_BYTES  = 2097152;
  localparam int HDR_LEN          = 12;

  localparam int POS_W  = 15;  // byte position, saturates at MAX_PACKET_BYTES
  localparam int PLEN_W = 15;
  localparam int FB_W   = 22;  // frame size register
  localparam int ADDR_W = 21;
  localparam int STAMP_W = 32;

  // header info bits
  localparam int HI_TOGGLE = 0;
  localparam int HI_EOF    = 1;
  localparam int HI_PTS    = 2;
  localparam int HI_ERR    = 6;

  localparam logic [FB_W-1:0] FRAME_BYTES_RST = FB_W'(1228800);

  // result kinds
  localparam logic [2:0] KIND_WRITE       = 3'd0;
  localparam logic [2:0] KIND_FRAME_START = 3'd1;
  localparam logic [2:0] KIND_BAD_HDR     = 3'd2;
  localparam logic [2:0] KIND_FRAME_ERR   = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW    = 3'd4;
  localparam logic [2:0] KIND_PTS_CHANGE  = 3'd5;

  // result queue
  localparam int MAX_PUSH = 3;
  localparam int Q_DEPTH  = 8;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              first_of_packet;
    logic [PLEN_W-1:0] packet_len;
    logic              buffer_ready;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [ADDR_W-1:0]  byte_addr;
    logic [7:0]         write_data;
    logic               frame_done;
    logic [STAMP_W-1:0] stamp;
    logic [FB_W-1:0]    lost_bytes;
    logic               frame_skipped;
    logic               last;
  } out_t;

  // results of one byte, in order, toward the queue
  typedef struct packed {
    logic [1:0]              cnt;
    out_t [MAX_PUSH-1:0]     res;
  } push_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
    logic            room;   // space for one more request in flight
  } q_stat_t;

endpackage

/* rtl/uvc_payload_frame_assembler.sv */
// One byte of a USB video payload packet is accepted per cycle while the
// result queue has room; each byte is registered, parsed in the following
// cycle and its results (none, one, or up to three on the last header byte)
// enter an eight-entry queue that presents one result per cycle on out_
// while out_ready is high. Sustained rate is one byte per cycle when every
// byte yields at most one result; header ends that yield several results
// drain at one per cycle, set by the single output port of the queue.
// frame_bytes may be written only while the block is idle.
// ----------------------------------------------------------------------------
// uvc_payload_frame_assembler
// Payload header parser and frame-buffer write generator, top level.
// ----------------------------------------------------------------------------
`include "uvc_payload_frame_assembler_macros.svh"

module uvc_payload_frame_assembler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  uvc_pfa_pkg::in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output uvc_pfa_pkg::out_t            out_data,
  input  logic                         cfg_wr_en,
  input  logic [uvc_pfa_pkg::FB_W-1:0] cfg_wr_data
);

  logic                         in_vld_r;
  uvc_pfa_pkg::in_t             in_item_r;
  logic [uvc_pfa_pkg::FB_W-1:0] frame_bytes_r;
  uvc_pfa_pkg::push_t           push;
  uvc_pfa_pkg::q_stat_t         q_stat;
  logic                         accept;

  assign in_ready = q_stat.room;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      frame_bytes_r <= uvc_pfa_pkg::FRAME_BYTES_RST;
    end else begin
      in_vld_r <= accept;
      if (cfg_wr_en)
        frame_bytes_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)
      in_item_r <= in_data;
  end

  uvc_pfa_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (in_vld_r),
    .item        (in_item_r),
    .frame_bytes (frame_bytes_r),
    .push        (push)
  );

  uvc_pfa_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (q_stat)
  );

  `UVC_PFA_ASSERT_NOW(a_queue_fits, clk, rst_n, in_vld_r,
    ({1'b0, q_stat.count} + 5'(push.cnt)) <= 5'(uvc_pfa_pkg::Q_DEPTH))
  `UVC_PFA_ASSERT_NOW(a_done_is_write, clk, rst_n, out_valid && out_data.frame_done,
    out_data.kind == uvc_pfa_pkg::KIND_WRITE)
  `UVC_PFA_ASSERT_NOW(a_single_last, clk, rst_n,
    out_valid && (out_data.kind == uvc_pfa_pkg::KIND_BAD_HDR ||
                  out_data.kind == uvc_pfa_pkg::KIND_FRAME_ERR ||
                  out_data.kind == uvc_pfa_pkg::KIND_OVERFLOW ||
                  out_data.kind == uvc_pfa_pkg::KIND_WRITE),
    out_data.last)
  `UVC_PFA_ASSERT_NEXT(a_no_push_idle, clk, rst_n, !accept, push.cnt == 2'd0)

endmodule

/* rtl/uvc_pfa_parse.sv */
// ----------------------------------------------------------------------------
// uvc_pfa_parse
// Header parse and frame tracking: one registered byte in, up to three results.
// ----------------------------------------------------------------------------
module uvc_pfa_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_vld,
  input  uvc_pfa_pkg::in_t            item,
  input  logic [uvc_pfa_pkg::FB_W-1:0] frame_bytes,
  output uvc_pfa_pkg::push_t          push
);

  logic [uvc_pfa_pkg::POS_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic [7:0]                      hinfo_r, hinfo_nxt;
  logic                            hok_r, hok_nxt;
  logic [uvc_pfa_pkg::STAMP_W-1:0] pstamp_r, pstamp_nxt;
  logic                            tog_r, tog_nxt;
  logic [uvc_pfa_pkg::STAMP_W-1:0] cstamp_r, cstamp_nxt;
  logic [uvc_pfa_pkg::ADDR_W-1:0]  coll_r, coll_nxt;
  logic                            skip_r, skip_nxt;
  logic                            drop_r, drop_nxt;
  logic [uvc_pfa_pkg::ADDR_W-1:0]  wp_r, wp_nxt;

  always_comb begin
    logic [uvc_pfa_pkg::FB_W-1:0]    fs;
    logic [uvc_pfa_pkg::POS_W-1:0]   pos;
    logic [uvc_pfa_pkg::PLEN_W-1:0]  plen;
    logic [uvc_pfa_pkg::PLEN_W-1:0]  pay;
    logic [7:0]                      data;
    logic [uvc_pfa_pkg::STAMP_W-1:0] pts;
    logic [uvc_pfa_pkg::FB_W-1:0]    lost;
    logic [uvc_pfa_pkg::FB_W-1:0]    fill;
    logic [uvc_pfa_pkg::FB_W-1:0]    wp_inc;
    logic [uvc_pfa_pkg::ADDR_W-1:0]  coll1;
    logic                            hdr_end;
    logic                            cand_a, cand_b, cand_c;
    logic [1:0]                      n;
    uvc_pfa_pkg::out_t               res_a, res_b, res_c, single;
    uvc_pfa_pkg::out_t [uvc_pfa_pkg::MAX_PUSH-1:0] res;

    fs   = (frame_bytes > uvc_pfa_pkg::FB_W'(uvc_pfa_pkg::MAX_FRAME_BYTES)) ?
           uvc_pfa_pkg::FB_W'(uvc_pfa_pkg::MAX_FRAME_BYTES) : frame_bytes;
    data = item.data_byte;
    plen = item.packet_len;
    pay  = plen - uvc_pfa_pkg::PLEN_W'(uvc_pfa_pkg::HDR_LEN);
    pos  = item.first_of_packet ? '0 : byte_pos_r;

    byte_pos_nxt = (pos < uvc_pfa_pkg::POS_W'(uvc_pfa_pkg::MAX_PACKET_BYTES)) ?
                   pos + uvc_pfa_pkg::POS_W'(1) : pos;
    drop_nxt   = item.first_of_packet ? 1'b0 : drop_r;
    hok_nxt    = item.first_of_packet ? 1'b0 : hok_r;
    hinfo_nxt  = hinfo_r;
    pstamp_nxt = pstamp_r;
    tog_nxt    = tog_r;
    cstamp_nxt = cstamp_r;
    coll_nxt   = coll_r;
    skip_nxt   = skip_r;
    wp_nxt     = wp_r;

    pts    = hinfo_r[uvc_pfa_pkg::HI_PTS] ? pstamp_r : '1;
    lost   = '0;
    fill   = '0;
    wp_inc = '0;
    coll1  = coll_r;
    hdr_end = 1'b0;
    cand_a = 1'b0;
    cand_b = 1'b0;
    cand_c = 1'b0;
    res_a  = '0;
    res_b  = '0;
    res_c  = '0;
    single = '0;
    n      = 2'd0;

    if (!(pos >= plen || drop_nxt)) begin
      if (pos == '0) begin
        hok_nxt    = 1'b0;
        hinfo_nxt  = '0;
        pstamp_nxt = '0;
        if (plen == uvc_pfa_pkg::PLEN_W'(uvc_pfa_pkg::HDR_LEN)) begin
          // header-only packet: ignore silently
          drop_nxt = 1'b1;
        end else if (plen < uvc_pfa_pkg::PLEN_W'(uvc_pfa_pkg::HDR_LEN) ||
                     plen > uvc_pfa_pkg::PLEN_W'(uvc_pfa_pkg::MAX_PACKET_BYTES) ||
                     data != 8'(uvc_pfa_pkg::HDR_LEN)) begin
          drop_nxt    = 1'b1;
          single.kind = uvc_pfa_pkg::KIND_BAD_HDR;
          n           = 2'd1;
        end
      end else if (pos == uvc_pfa_pkg::POS_W'(1)) begin
        hinfo_nxt = data;
        if (data[uvc_pfa_pkg::HI_ERR]) begin
          drop_nxt    = 1'b1;
          single.kind = uvc_pfa_pkg::KIND_FRAME_ERR;
          n           = 2'd1;
        end
      end else if (pos < uvc_pfa_pkg::POS_W'(6)) begin
        // little-endian stamp at bytes 2..5
        case (pos[1:0])
          2'd2:    pstamp_nxt[7:0]   = pstamp_r[7:0]   | data;
          2'd3:    pstamp_nxt[15:8]  = pstamp_r[15:8]  | data;
          2'd0:    pstamp_nxt[23:16] = pstamp_r[23:16] | data;
          default: pstamp_nxt[31:24] = pstamp_r[31:24] | data;
        endcase
      end else if (pos == uvc_pfa_pkg::POS_W'(uvc_pfa_pkg::HDR_LEN - 1)) begin
        hdr_end = 1'b1;
        cand_a  = hinfo_r[uvc_pfa_pkg::HI_PTS] && coll_r != '0 && pts != cstamp_r;
        cand_b  = hinfo_r[uvc_pfa_pkg::HI_TOGGLE] != tog_r;
        if (coll_r != '0 && fs > uvc_pfa_pkg::FB_W'(coll_r))
          lost = fs - uvc_pfa_pkg::FB_W'(coll_r);
        if (cand_a || cand_b)
          cstamp_nxt = pts;
        if (cand_b) begin
          tog_nxt  = hinfo_r[uvc_pfa_pkg::HI_TOGGLE];
          coll1    = '0;
          skip_nxt = !item.buffer_ready;
        end
        coll_nxt = coll1;
        fill     = uvc_pfa_pkg::FB_W'(coll1) + uvc_pfa_pkg::FB_W'(pay);
        if (skip_nxt) begin
          drop_nxt = 1'b1;
        end else if (fill > fs) begin
          drop_nxt = 1'b1;
          cand_c   = 1'b1;
        end else begin
          hok_nxt = 1'b1;
          wp_nxt  = coll1;
        end
        res_a.kind          = uvc_pfa_pkg::KIND_PTS_CHANGE;
        res_a.stamp         = pts;
        res_b.kind          = uvc_pfa_pkg::KIND_FRAME_START;
        res_b.stamp         = pts;
        res_b.lost_bytes    = lost;
        res_b.frame_skipped = skip_nxt;
        res_c.kind          = uvc_pfa_pkg::KIND_OVERFLOW;
        n = {1'b0, cand_a} + {1'b0, cand_b} + {1'b0, cand_c};
      end else if (pos >= uvc_pfa_pkg::POS_W'(uvc_pfa_pkg::HDR_LEN) && hok_nxt) begin
        wp_inc            = uvc_pfa_pkg::FB_W'(wp_r) + uvc_pfa_pkg::FB_W'(1);
        single.kind       = uvc_pfa_pkg::KIND_WRITE;
        single.byte_addr  = wp_r;
        single.write_data = data;
        n                 = 2'd1;
        if (wp_inc == fs) begin
          // frame filled: wrap
          single.frame_done = 1'b1;
          wp_nxt   = '0;
          coll_nxt = '0;
        end else begin
          wp_nxt = wp_inc[uvc_pfa_pkg::ADDR_W-1:0];
        end
        if (pos == plen - uvc_pfa_pkg::PLEN_W'(1)) begin
          coll_nxt = wp_nxt;
          if (hinfo_r[uvc_pfa_pkg::HI_EOF]) begin
            coll_nxt = '0;
            wp_nxt   = '0;
          end
          hok_nxt = 1'b0;
        end
      end
    end

    // pack the ordered results into the low slots
    if (hdr_end) begin
      res[0] = cand_a ? res_a : (cand_b ? res_b : res_c);
      res[1] = (cand_a && cand_b) ? res_b : res_c;
      res[2] = res_c;
    end else begin
      res[0] = single;
      res[1] = '0;
      res[2] = '0;
    end
    for (int i = 0; i < uvc_pfa_pkg::MAX_PUSH; i++)
      res[i].last = (n == 2'(i + 1));

    push.res = res;
    push.cnt = item_vld ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      hinfo_r    <= '0;
      hok_r      <= 1'b0;
      pstamp_r   <= '0;
      tog_r      <= 1'b0;
      cstamp_r   <= '1;
      coll_r     <= '0;
      skip_r     <= 1'b1;
      drop_r     <= 1'b0;
      wp_r       <= '0;
    end else if (item_vld) begin
      byte_pos_r <= byte_pos_nxt;
      hinfo_r    <= hinfo_nxt;
      hok_r      <= hok_nxt;
      pstamp_r   <= pstamp_nxt;
      tog_r      <= tog_nxt;
      cstamp_r   <= cstamp_nxt;
      coll_r     <= coll_nxt;
      skip_r     <= skip_nxt;
      drop_r     <= drop_nxt;
      wp_r       <= wp_nxt;
    end
  end

endmodule

/* rtl/uvc_pfa_result_queue.sv */
// ----------------------------------------------------------------------------
// uvc_pfa_result_queue
// Result queue: up to three pushes per cycle, one pop per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module uvc_pfa_result_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uvc_pfa_pkg::push_t   push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uvc_pfa_pkg::out_t    out_data,
  output uvc_pfa_pkg::q_stat_t stat
);

  uvc_pfa_pkg::out_t            mem_r [uvc_pfa_pkg::Q_DEPTH];
  logic [uvc_pfa_pkg::Q_AW-1:0] head_r, head_nxt;
  logic [uvc_pfa_pkg::Q_AW-1:0] tail_r, tail_nxt;
  logic [uvc_pfa_pkg::Q_CW-1:0] count_r, count_nxt;
  logic                         pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[head_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    head_nxt  = pop ? head_r + uvc_pfa_pkg::Q_AW'(1) : head_r;
    tail_nxt  = tail_r + uvc_pfa_pkg::Q_AW'(push.cnt);
    count_nxt = count_r + uvc_pfa_pkg::Q_CW'(push.cnt) - uvc_pfa_pkg::Q_CW'(pop);
  end

  // reserve room for the request in the input register and one more
  assign stat.count = count_r;
  assign stat.room  = count_r <= uvc_pfa_pkg::Q_CW'(uvc_pfa_pkg::Q_DEPTH -
                                                    2 * uvc_pfa_pkg::MAX_PUSH);

  always_ff @(posedge clk) begin
    for (int i = 0; i < uvc_pfa_pkg::MAX_PUSH; i++) begin
      if (2'(i) < push.cnt)
        mem_r[tail_r + uvc_pfa_pkg::Q_AW'(i)] <= push.res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* dv/uvc_payload_frame_assembler_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uvc_payload_frame_assembler_tb
// Self-checking bench for the payload frame assembler. Streams header and
// payload bytes over the request channel, models header parsing, frame
// tracking and buffer writes in the bench, and checks every result in order.
// ----------------------------------------------------------------------------
module uvc_payload_frame_assembler_tb;

  localparam int CLK_HALF      = 5;
  localparam int RST_CYCLES    = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 3000;
  localparam int REPORT_MAX    = 10;
  localparam int IN_W          = $bits(uvc_pfa_pkg::in_t);

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  uvc_pfa_pkg::in_t             in_data;
  logic                         out_valid;
  logic                         out_ready;
  uvc_pfa_pkg::out_t            out_data;
  logic                         cfg_wr_en;
  logic [uvc_pfa_pkg::FB_W-1:0] cfg_wr_data;

  uvc_payload_frame_assembler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // events the assembler still owes, oldest first
  uvc_pfa_pkg::out_t frame_events[$];
  uvc_pfa_pkg::out_t due_event;

  int errors;
  int idle_cycles;
  int bytes_parsed;
  int results_seen;
  int starts_seen;
  int fills_seen;
  int drops_seen;
  int stamps_seen;
  int sizes_run;
  bit src_gaps;
  bit sink_stalls;
  bit hold_request;

  // bench copy of the parser and frame state
  logic [uvc_pfa_pkg::FB_W-1:0]    fb_size;
  logic [uvc_pfa_pkg::POS_W-1:0]   byte_idx;
  logic [7:0]                      hdr_bits;
  bit                              hdr_good;
  logic [uvc_pfa_pkg::STAMP_W-1:0] pkt_pts;
  bit                              frame_tgl;
  logic [uvc_pfa_pkg::STAMP_W-1:0] frame_pts;
  logic [uvc_pfa_pkg::FB_W-1:0]    committed;
  bit                              skipping;
  bit                              dropping;
  logic [uvc_pfa_pkg::FB_W-1:0]    wr_addr;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("ERROR: %s", msg);
  endfunction

  function automatic string event_str(uvc_pfa_pkg::out_t e);
    return $sformatf({"kind=%0d addr=%0h data=%02h done=%0b stamp=%08h",
                      " lost=%0d skip=%0b last=%0b"},
                     e.kind, e.byte_addr, e.write_data, e.frame_done, e.stamp,
                     e.lost_bytes, e.frame_skipped, e.last);
  endfunction

  function automatic uvc_pfa_pkg::out_t blank_event(logic [2:0] kind);
    uvc_pfa_pkg::out_t e;
    e = '0;
    e.kind = kind;
    return e;
  endfunction

  function automatic void clear_assembly();
    fb_size   = uvc_pfa_pkg::FRAME_BYTES_RST;
    byte_idx  = '0;
    hdr_bits  = '0;
    hdr_good  = 1'b0;
    pkt_pts   = '0;
    frame_tgl = 1'b0;
    frame_pts = '1;
    committed = '0;
    skipping  = 1'b1;
    dropping  = 1'b0;
    wr_addr   = '0;
  endfunction

  // Advance the parser by one byte and queue what it emits; 0 if ignored.
  function automatic bit parse_byte(uvc_pfa_pkg::in_t b);
    uvc_pfa_pkg::out_t               evs[$];
    uvc_pfa_pkg::out_t               ev;
    int unsigned                     p;
    int unsigned                     plen;
    logic [uvc_pfa_pkg::FB_W-1:0]    fs;
    logic [uvc_pfa_pkg::FB_W-1:0]    lost;
    logic [uvc_pfa_pkg::FB_W-1:0]    addr;
    logic [uvc_pfa_pkg::STAMP_W-1:0] pts;
    fs   = (fb_size > uvc_pfa_pkg::FB_W'(uvc_pfa_pkg::MAX_FRAME_BYTES)) ?
           uvc_pfa_pkg::FB_W'(uvc_pfa_pkg::MAX_FRAME_BYTES) : fb_size;
    plen = b.packet_len;
    if (b.first_of_packet) begin
      byte_idx = '0;
      dropping = 1'b0;
      hdr_good = 1'b0;
    end
    p = byte_idx;
    if (p < uvc_pfa_pkg::MAX_PACKET_BYTES) byte_idx++;
    if (p >= plen || dropping) return 1'b0;

    if (p == 0) begin
      hdr_good = 1'b0;
      hdr_bits = '0;
      pkt_pts  = '0;
      if (plen == uvc_pfa_pkg::HDR_LEN) begin
        dropping = 1'b1;
      end else if (plen < uvc_pfa_pkg::HDR_LEN || plen > uvc_pfa_pkg::MAX_PACKET_BYTES ||
                   b.data_byte != uvc_pfa_pkg::HDR_LEN) begin
        dropping = 1'b1;
        evs.push_back(blank_event(uvc_pfa_pkg::KIND_BAD_HDR));
      end
    end else if (p == 1) begin
      hdr_bits = b.data_byte;
      if (b.data_byte[uvc_pfa_pkg::HI_ERR]) begin
        dropping = 1'b1;
        evs.push_back(blank_event(uvc_pfa_pkg::KIND_FRAME_ERR));
      end
    end else if (p < 6) begin
      pkt_pts |= uvc_pfa_pkg::STAMP_W'(b.data_byte) << (8 * (p - 2));
    end else if (p == uvc_pfa_pkg::HDR_LEN - 1) begin
      pts = hdr_bits[uvc_pfa_pkg::HI_PTS] ? pkt_pts : '1;
      if (hdr_bits[uvc_pfa_pkg::HI_PTS] && committed != 0 && pts != frame_pts) begin
        frame_pts = pts;
        ev = blank_event(uvc_pfa_pkg::KIND_PTS_CHANGE);
        ev.stamp = pts;
        evs.push_back(ev);
      end
      if (hdr_bits[uvc_pfa_pkg::HI_TOGGLE] != frame_tgl) begin
        lost = '0;
        if (committed > 0 && fs > committed) lost = fs - committed;
        frame_tgl = hdr_bits[uvc_pfa_pkg::HI_TOGGLE];
        frame_pts = pts;
        committed = '0;
        skipping  = !b.buffer_ready;
        ev = blank_event(uvc_pfa_pkg::KIND_FRAME_START);
        ev.stamp         = pts;
        ev.lost_bytes    = lost;
        ev.frame_skipped = skipping;
        evs.push_back(ev);
      end
      if (skipping) begin
        dropping = 1'b1;
      end else if (committed + plen - uvc_pfa_pkg::HDR_LEN > fs) begin
        dropping = 1'b1;
        evs.push_back(blank_event(uvc_pfa_pkg::KIND_OVERFLOW));
      end else begin
        hdr_good = 1'b1;
        wr_addr  = committed;
      end
    end else if (p >= uvc_pfa_pkg::HDR_LEN && hdr_good) begin
      addr = wr_addr;
      ev = blank_event(uvc_pfa_pkg::KIND_WRITE);
      ev.byte_addr  = addr[uvc_pfa_pkg::ADDR_W-1:0];
      ev.write_data = b.data_byte;
      wr_addr++;
      if (wr_addr == fs) begin
        ev.frame_done = 1'b1;
        wr_addr   = '0;
        committed = '0;
      end
      evs.push_back(ev);
      if (p == plen - 1) begin
        committed = wr_addr;
        if (hdr_bits[uvc_pfa_pkg::HI_EOF]) begin
          committed = '0;
          wr_addr   = '0;
        end
        hdr_good = 1'b0;
      end
    end

    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) frame_events.push_back(evs[i]);
    return 1'b1;
  endfunction

  // Offer one byte and hold the request until the block takes it.
  task automatic send_byte(uvc_pfa_pkg::in_t b);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    if (parse_byte(b)) bytes_parsed++;
  endtask

  // Send nbytes of a packet: length byte, info, stamp, filler, payload.
  task automatic send_packet(int plen, logic [7:0] hlen, logic [7:0] info,
                             logic [31:0] pts, bit ready, int nbytes, bit mark);
    uvc_pfa_pkg::in_t b;
    for (int i = 0; i < nbytes; i++) begin
      b.first_of_packet = (i == 0) && mark;
      b.packet_len      = uvc_pfa_pkg::PLEN_W'(plen);
      b.buffer_ready    = (i == uvc_pfa_pkg::HDR_LEN - 1) ? ready :
                          1'($urandom_range(0, 1));
      if (i == 0)      b.data_byte = hlen;
      else if (i == 1) b.data_byte = info;
      else if (i < 6)  b.data_byte = pts[8*(i-2) +: 8];
      else             b.data_byte = 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_size(logic [uvc_pfa_pkg::FB_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    fb_size = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed packets with random content, some noise and faults.
  task automatic random_packet();
    int               pay;
    int               plen;
    int               nbytes;
    logic [7:0]       info;
    logic [31:0]      pts;
    bit               ready;
    uvc_pfa_pkg::in_t junk;
    case ($urandom_range(0, 15))
      0: begin
        junk = IN_W'($urandom);
        send_byte(junk);
      end
      1: send_packet($urandom_range(1, 20), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), $urandom, 1'b1, 2, 1'b1);
      default: begin
        pay  = $urandom_range(1, 6);
        plen = uvc_pfa_pkg::HDR_LEN + pay;
        info = 8'($urandom_range(0, 255));
        info[uvc_pfa_pkg::HI_TOGGLE] = frame_tgl ^ ($urandom_range(0, 3) == 0);
        info[uvc_pfa_pkg::HI_EOF]    = ($urandom_range(0, 4) == 0);
        info[uvc_pfa_pkg::HI_PTS]    = 1'($urandom_range(0, 1));
        info[uvc_pfa_pkg::HI_ERR]    = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 2))
          0:       pts = 32'h0000_0100;
          1:       pts = 32'hFFFF_FFFF;
          default: pts = $urandom;
        endcase
        ready  = ($urandom_range(0, 7) != 0);
        nbytes = plen;
        case ($urandom_range(0, 9))
          0:       nbytes = $urandom_range(1, plen - 1);
          1:       nbytes = plen + $urandom_range(1, 3);
          default: ;
        endcase
        send_packet(plen, 8'(uvc_pfa_pkg::HDR_LEN), info, pts, ready, nbytes, 1'b1);
      end
    endcase
  endtask

  task automatic run_packets(int budget);
    int start;
    start = bytes_parsed;
    while (bytes_parsed - start < budget) random_packet();
  endtask

  // First packet after reset carries no first mark; it is also cut short.
  task automatic test_unmarked_start();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    send_packet(uvc_pfa_pkg::MAX_PACKET_BYTES, 8'(uvc_pfa_pkg::HDR_LEN), 8'h05,
                32'h89AB_CDEF, 1'b1, uvc_pfa_pkg::HDR_LEN + 2, 1'b0);
  endtask

  task automatic test_header_faults();
    send_packet(1, 8'(uvc_pfa_pkg::HDR_LEN), 8'h00, '0, 1'b1, 1, 1'b1);
    send_packet(11, 8'(uvc_pfa_pkg::HDR_LEN), 8'h00, '0, 1'b1, 1, 1'b1);
    // header-only: silent even with the toggle flipped
    send_packet(uvc_pfa_pkg::HDR_LEN, 8'(uvc_pfa_pkg::HDR_LEN), 8'h00, '0, 1'b1, 2, 1'b1);
    send_packet(0, 8'h00, 8'h00, '0, 1'b1, 1, 1'b1);
    send_packet(uvc_pfa_pkg::MAX_PACKET_BYTES + 1, 8'(uvc_pfa_pkg::HDR_LEN), 8'h00, '0,
                1'b1, 1, 1'b1);
    send_packet(32767, 8'hFF, 8'h00, '0, 1'b1, 1, 1'b1);
    send_packet(20, 8'd13, 8'h00, '0, 1'b1, 1, 1'b1);
    send_packet(20, 8'(uvc_pfa_pkg::HDR_LEN), 8'hFF, '0, 1'b1, 2, 1'b1);
    // stray byte of the dropped packet
    send_packet(20, 8'h00, 8'h00, '0, 1'b1, 1, 1'b0);
  endtask

  task automatic test_frame_sizes();
    logic [uvc_pfa_pkg::FB_W-1:0] sizes [3];
    sizes[0] = 1;
    sizes[1] = uvc_pfa_pkg::FB_W'($urandom_range(8, 24));
    // above the maximum: clamps to the largest frame
    sizes[2] = '1;
    foreach (sizes[i]) begin
      write_frame_size(sizes[i]);
      src_gaps    = ($urandom_range(0, 2) != 0);
      sink_stalls = ($urandom_range(0, 2) != 0);
      sizes_run++;
      run_packets(12);
    end
  endtask

  // Long receiver hold while a long packet keeps coming, then drain fully.
  task automatic test_backpressure();
    logic [7:0] info;
    src_gaps     = 1'b0;
    sink_stalls  = 1'b0;
    hold_request = 1'b1;
    info = 8'h04;
    info[uvc_pfa_pkg::HI_TOGGLE] = ~frame_tgl;
    send_packet(uvc_pfa_pkg::HDR_LEN + 10, 8'(uvc_pfa_pkg::HDR_LEN), info, $urandom, 1'b1,
                uvc_pfa_pkg::HDR_LEN + 10, 1'b1);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    write_frame_size(uvc_pfa_pkg::FB_W'($urandom_range(6, 20)));
    sizes_run++;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    run_packets(12);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    clear_assembly();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_unmarked_start();
    test_header_faults();
    test_frame_sizes();
    test_backpressure();
    test_steady_stream();
    wait_drained();

    $display("Covered %0d parsed bytes over %0d frame sizes, %0d results checked",
             bytes_parsed, sizes_run + 1, results_seen);
    $display("  frame starts %0d, filled frames %0d, dropped packets %0d, stamp changes %0d",
             starts_seen, fills_seen, drops_seen, stamps_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      case (out_data.kind)
        uvc_pfa_pkg::KIND_WRITE:       if (out_data.frame_done) fills_seen++;
        uvc_pfa_pkg::KIND_FRAME_START: starts_seen++;
        uvc_pfa_pkg::KIND_PTS_CHANGE:  stamps_seen++;
        default:                       drops_seen++;
      endcase
      if (frame_events.size() == 0) begin
        note_error($sformatf("unexpected result: %s", event_str(out_data)));
      end else begin
        due_event = frame_events.pop_front();
        if (out_data !== due_event)
          note_error($sformatf("result %0d\n  exp %s\n  got %s", results_seen,
                               event_str(due_event), event_str(out_data)));
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results still due",
               idle_cycles, frame_events.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+rtl
rtl/uvc_pfa_pkg.sv
rtl/uvc_pfa_parse.sv
rtl/uvc_pfa_result_queue.sv
rtl/uvc_payload_frame_assembler.sv
dv/uvc_payload_frame_assembler_tb.sv
